FILE: rtl/hgcd_pkg.sv
// Shared constants, tables and helpers for the haversine distance unit.
`timescale 1ns / 1ps
package hgcd_pkg;

  localparam int LAT_W = 30;
  localparam int LON_W = 31;
  localparam int ARC_W = 30;
  localparam int DIST_W = 29;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 64;

  localparam logic [31:0] FULL_TURN = 32'd1509949440;
  localparam logic [31:0] HALF_TURN = 32'd754974720;
  localparam logic [31:0] QUARTER_TURN = 32'd377487360;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;
  localparam logic [25:0] DEG2RAD_Q31 = 26'd37480660;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [30:0] RADIUS_Q8 = 31'd1631436176;

  // CORDIC datapath width (signed); values stay within about +-2^32
  localparam int CW = 36;

  typedef logic signed [CW-1:0] cw_t;

  function automatic cw_t atan_q30(input int i);
    unique case (i)
      0: atan_q30 = 36'sd843314857;
      1: atan_q30 = 36'sd497837829;
      2: atan_q30 = 36'sd263043837;
      3: atan_q30 = 36'sd133525159;
      4: atan_q30 = 36'sd67021687;
      5: atan_q30 = 36'sd33543516;
      6: atan_q30 = 36'sd16775851;
      7: atan_q30 = 36'sd8388437;
      8: atan_q30 = 36'sd4194283;
      9: atan_q30 = 36'sd2097149;
      default: atan_q30 = (i < 31) ? (cw_t'(1) <<< (30 - i)) : '0;
    endcase
  endfunction

  // reduce a difference (|d| < 2*FULL_TURN) to [0, HALF_TURN]
  function automatic logic [31:0] fold_diff(input logic signed [32:0] d);
    logic signed [32:0] r;
    r = d;
    if (r < 0) r = r + 33'(FULL_TURN);
    if (r < 0) r = r + 33'(FULL_TURN);
    if (r >= 33'(FULL_TURN)) r = r - 33'(FULL_TURN);
    if (r > 33'(HALF_TURN)) r = 33'(FULL_TURN) - r;
    fold_diff = r[31:0];
  endfunction

  function automatic logic [31:0] clamp_q30(input cw_t v);
    if (v < 0) clamp_q30 = '0;
    else if (v > cw_t'(ONE_Q30)) clamp_q30 = ONE_Q30;
    else clamp_q30 = v[31:0];
  endfunction

endpackage

FILE: rtl/haversine_great_circle_distance_unit.sv
// Top level: pipelined haversine great-circle distance unit.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_*): one request carries two positions, latitude and
//  longitude in signed 2^-22 degree units, packed into in_tdata.
//  Output channel (out_*): one result per request, the central arc in
//  2^-28 rad and the surface distance in 2^-4 m, packed into out_tdata.
//  Throughput: one request per cycle while the receiver does not stall. A fully pipelined chain of stages
//  (angle prep, radian scaling, CORDIC_STEPS rotation stages, four product
//  stages, two 32-stage bitwise square roots, CORDIC_STEPS vectoring
//  stages, two output scaling stages) carries each request.
//  Every stage holds a valid bit. The whole pipe advances when the last
//  stage is empty or its result is taken; when the receiver stalls the
//  pipe freezes and in_tready drops, so nothing is lost or repeated.
//  Reset clears all valid bits; payload registers are not reset.
//  No configuration, no state kept between requests.
module haversine_great_circle_distance_unit #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [29:0] first_latitude, [60:30] first_longitude,
  // [90:61] second_latitude, [121:91] second_longitude, rest zero
  input  logic [hgcd_pkg::IN_DATA_W-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // [29:0] central_arc, [58:30] surface_distance, rest zero
  output logic [hgcd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import hgcd_pkg::*;

  localparam int NS = CORDIC_STEPS;
  localparam int SQ = 32;           // square-root stages

  // global enable: advance when output slot is free or taken
  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- stage 1: unpack and fold ----------------
  logic signed [LAT_W-1:0] lat1, lat2;
  logic signed [LON_W-1:0] lon1, lon2;
  assign lat1 = in_tdata[29:0];
  assign lon1 = in_tdata[60:30];
  assign lat2 = in_tdata[90:61];
  assign lon2 = in_tdata[121:91];

  logic v1_r;
  logic [31:0] u_r [4]; // angles in 2^-23 deg: dlat, dlon, lat1, lat2
  logic n1_r, n2_r;

  function automatic logic [31:0] lat_abs2(input logic signed [LAT_W-1:0] l,
                                           output logic neg);
    logic [31:0] a;
    a = l[LAT_W-1] ? 32'(-33'(l)) : 32'(l);
    neg = 1'b0;
    if (a > QUARTER_TURN) begin
      a = HALF_TURN - a;
      neg = 1'b1;
    end
    lat_abs2 = a << 1;
  endfunction

  always_ff @(posedge clk) begin
    logic na, nb;
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
    if (adv) begin
      u_r[0] <= fold_diff(33'(lat1) - 33'(lat2));
      u_r[1] <= fold_diff(33'(lon1) - 33'(lon2));
      u_r[2] <= lat_abs2(lat1, na);
      u_r[3] <= lat_abs2(lat2, nb);
      n1_r <= na;
      n2_r <= nb;
    end
  end

  // ---------------- stage 2: to radians ----------------
  logic v2_r;
  cw_t th_r [4];
  logic n1b_r, n2b_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        th_r[k] <= cw_t'((58'(u_r[k]) * 58'(DEG2RAD_Q31) + (58'(1) << 23)) >> 24);
      end
      n1b_r <= n1_r;
      n2b_r <= n2_r;
    end
  end

  // ---------------- rotation CORDIC, four lanes ----------------
  cw_t rx_r [NS+1][4];
  cw_t ry_r [NS+1][4];
  cw_t rz_r [NS+1][4];
  logic rv_r [NS+1];
  logic rn1_r [NS+1];
  logic rn2_r [NS+1];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rx_r[0][k] = cw_t'(CORDIC_GAIN_Q30);
      ry_r[0][k] = '0;
      rz_r[0][k] = th_r[k];
    end
    rv_r[0] = v2_r;
    rn1_r[0] = n1b_r;
    rn2_r[0] = n2b_r;
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!rst_n) rv_r[i+1] <= 1'b0;
      else if (adv) rv_r[i+1] <= rv_r[i];
      if (adv) begin
        rn1_r[i+1] <= rn1_r[i];
        rn2_r[i+1] <= rn2_r[i];
        for (int k = 0; k < 4; k++) begin
          if (rz_r[i][k] >= 0) begin
            rx_r[i+1][k] <= rx_r[i][k] - (ry_r[i][k] >>> i);
            ry_r[i+1][k] <= ry_r[i][k] + (rx_r[i][k] >>> i);
            rz_r[i+1][k] <= rz_r[i][k] - atan_q30(i);
          end else begin
            rx_r[i+1][k] <= rx_r[i][k] + (ry_r[i][k] >>> i);
            ry_r[i+1][k] <= ry_r[i][k] - (rx_r[i][k] >>> i);
            rz_r[i+1][k] <= rz_r[i][k] + atan_q30(i);
          end
        end
      end
    end
  end

  // ---------------- product stages ----------------
  function automatic logic [31:0] mq(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + (64'(1) << 29);
    mq = p[61:30];
  endfunction

  logic [31:0] sl_r, so_r, cc_r, slb_r, sob_r, trm_r, slc_r;
  logic p1v_r, p2v_r, p3v_r, p4v_r;
  logic ng1_r, ng2_r, ng3_r;
  logic [31:0] s0, s1, c2, c3;
  assign s0 = clamp_q30(ry_r[NS][0]);
  assign s1 = clamp_q30(ry_r[NS][1]);
  assign c2 = clamp_q30(rx_r[NS][2]);
  assign c3 = clamp_q30(rx_r[NS][3]);

  cw_t hs;
  assign hs = ng3_r ? (cw_t'(slc_r) - cw_t'(trm_r)) : (cw_t'(slc_r) + cw_t'(trm_r));

  logic [31:0] h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= 1'b0; p2v_r <= 1'b0; p3v_r <= 1'b0; p4v_r <= 1'b0;
    end else if (adv) begin
      p1v_r <= rv_r[NS]; p2v_r <= p1v_r; p3v_r <= p2v_r; p4v_r <= p3v_r;
    end
    if (adv) begin
      sl_r <= mq(s0, s0);
      so_r <= mq(s1, s1);
      cc_r <= mq(c2, c3);
      ng1_r <= rn1_r[NS] != rn2_r[NS];
      slb_r <= sl_r;
      sob_r <= mq(cc_r, so_r);
      ng2_r <= ng1_r;
      slc_r <= slb_r;
      trm_r <= sob_r;
      ng3_r <= ng2_r;
      h_r <= clamp_q30(hs);
    end
  end

  // ---------------- two bitwise square roots ----------------
  // remainder / root / bit per stage, one bit pair per stage
  logic [63:0] qa_r [SQ+1], qb_r [SQ+1];
  logic [63:0] ra_r [SQ+1], rb_r [SQ+1];
  logic qv_r [SQ+1];

  always_comb begin
    qa_r[0] = 64'(h_r) << 30;
    qb_r[0] = 64'(ONE_Q30 - h_r) << 30;
    ra_r[0] = '0;
    rb_r[0] = '0;
    qv_r[0] = p4v_r;
  end

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    always_ff @(posedge clk) begin
      if (!rst_n) qv_r[j+1] <= 1'b0;
      else if (adv) qv_r[j+1] <= qv_r[j];
      if (adv) begin
        if (qa_r[j] >= ra_r[j] + BIT) begin
          qa_r[j+1] <= qa_r[j] - (ra_r[j] + BIT);
          ra_r[j+1] <= (ra_r[j] >> 1) + BIT;
        end else begin
          qa_r[j+1] <= qa_r[j];
          ra_r[j+1] <= ra_r[j] >> 1;
        end
        if (qb_r[j] >= rb_r[j] + BIT) begin
          qb_r[j+1] <= qb_r[j] - (rb_r[j] + BIT);
          rb_r[j+1] <= (rb_r[j] >> 1) + BIT;
        end else begin
          qb_r[j+1] <= qb_r[j];
          rb_r[j+1] <= rb_r[j] >> 1;
        end
      end
    end
  end

  // ---------------- vectoring CORDIC ----------------
  cw_t vx_r [NS+1], vy_r [NS+1], vz_r [NS+1];
  logic vv_r [NS+1];
  always_comb begin
    vx_r[0] = cw_t'(rb_r[SQ][31:0]);
    vy_r[0] = cw_t'(ra_r[SQ][31:0]);
    vz_r[0] = '0;
    vv_r[0] = qv_r[SQ];
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (!rst_n) vv_r[i+1] <= 1'b0;
      else if (adv) vv_r[i+1] <= vv_r[i];
      if (adv) begin
        if (vy_r[i] >= 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + atan_q30(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - atan_q30(i);
        end
      end
    end
  end

  // ---------------- output scaling ----------------
  logic [31:0] zc;
  always_comb begin
    if (vz_r[NS] < 0) zc = '0;
    else if (vz_r[NS] > cw_t'(HALF_PI_Q30)) zc = HALF_PI_Q30;
    else zc = vz_r[NS][31:0];
  end

  logic o1v_r, o2v_r;
  logic [31:0] z1_r;
  logic [63:0] zp_r;
  logic [ARC_W-1:0] arc_r;
  logic [DIST_W-1:0] dist_r;
  logic [63:0] zs;
  assign zs = zp_r + (64'(1) << 32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1v_r <= 1'b0; o2v_r <= 1'b0;
    end else if (adv) begin
      o1v_r <= vv_r[NS]; o2v_r <= o1v_r;
    end
    if (adv) begin
      z1_r <= zc;
      zp_r <= 64'(zc) * 64'(RADIUS_Q8);
      arc_r <= ARC_W'((33'(z1_r) + 33'd1) >> 1);
      dist_r <= zs[33+DIST_W-1:33];
    end
  end

  assign out_tvalid = o2v_r;
  assign out_tdata = {{(OUT_DATA_W-ARC_W-DIST_W){1'b0}}, dist_r, arc_r};

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("ready not tied to output slot");
  a_arc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[29:0] <= 30'd843314857)
    else $error("arc out of range");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tdata[OUT_DATA_W-1:ARC_W+DIST_W] == '0)
    else $error("padding not zero");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && o1v_r |=> out_tvalid)
    else $error("result lost in final stage");
`endif

endmodule

FILE: tb/tb_haversine_great_circle_distance_unit.sv
// Testbench for the haversine great-circle distance unit: random and directed position pairs.
`timescale 1ns / 1ps
module tb_haversine_great_circle_distance_unit;
  import hgcd_pkg::*;

  localparam int LATENCY = 2 * 24 + 40;
  localparam int N_RANDOM = 1450;
  localparam int QUIET_TAIL = 150;

  // One request: two positions in signed 2^-22 degree units.
  typedef struct packed {
    logic signed [LAT_W-1:0] lat1;
    logic signed [LON_W-1:0] lon1;
    logic signed [LAT_W-1:0] lat2;
    logic signed [LON_W-1:0] lon2;
  } position_pair_t;

  typedef struct packed {
    logic [ARC_W-1:0] arc;
    logic [DIST_W-1:0] surf_dist;
  } arc_distance_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  position_pair_t pending_pairs[$];
  arc_distance_t expected_arcs[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  bit quiet = 1'b0; // no idling on either side in the final stretch
  int send_gap = 0;
  int recv_gap = 0;

  haversine_great_circle_distance_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor: fixed-point haversine with CORDIC sin/cos and atan2.
  // ---------------------------------------------------------------------
  localparam longint ATAN_TBL[0:31] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0};
  localparam int STEPS = 24;

  function automatic longint sat_q30(longint v);
    if (v < 0) return 0;
    if (v > 64'sd1073741824) return 64'sd1073741824;
    return v;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(r);
  endfunction

  // u in 2^-23 degree units, 0..90 degrees -> Q30 radians
  function automatic longint deg_to_q30(longint u);
    return (u * 64'sd37480660 + (64'sd1 << 23)) >>> 24;
  endfunction

  function automatic void rotate_unit(longint theta, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 64'sd652032874;
    y = 0;
    z = theta;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    c = sat_q30(x);
    s = sat_q30(y);
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  // sin^2 of half a difference, difference folded into [0, 180] degrees
  function automatic longint half_angle_sin_sq(longint d);
    longint r, c, s;
    r = d % longint'(FULL_TURN);
    if (r < 0) r += longint'(FULL_TURN);
    if (r > longint'(HALF_TURN)) r = longint'(FULL_TURN) - r;
    rotate_unit(deg_to_q30(r), c, s);
    return q30_mul(s, s);
  endfunction

  // |cos(lat)|; latitudes past the pole flip the sign
  function automatic longint lat_cosine(longint lat, output bit neg);
    longint a, c, s;
    a = (lat < 0) ? -lat : lat;
    neg = 1'b0;
    if (a > longint'(QUARTER_TURN)) begin
      a = longint'(HALF_TURN) - a;
      neg = 1'b1;
    end
    rotate_unit(deg_to_q30(a * 2), c, s);
    return c;
  endfunction

  function automatic arc_distance_t predict_arc_distance(position_pair_t p);
    longint slat, slon, c1, c2, term, h, a, b, z;
    longint unsigned zu;
    bit n1, n2;
    arc_distance_t res;
    slat = half_angle_sin_sq(longint'(p.lat1) - longint'(p.lat2));
    slon = half_angle_sin_sq(longint'(p.lon1) - longint'(p.lon2));
    c1 = lat_cosine(longint'(p.lat1), n1);
    c2 = lat_cosine(longint'(p.lat2), n2);
    term = q30_mul(q30_mul(c1, c2), slon);
    h = (n1 != n2) ? slat - term : slat + term;
    h = sat_q30(h);
    a = floor_sqrt(longint'(h) << 30);
    b = floor_sqrt((64'sd1073741824 - h) << 30);
    z = vector_angle(b, a);
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
    zu = longint'(z);
    res.arc = ARC_W'((zu + 1) >> 1);
    res.surf_dist = DIST_W'((zu * 64'd1631436176 + (64'd1 << 32)) >> 33);
    return res;
  endfunction

  function automatic void queue_pair(position_pair_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued requests, idles in random bursts.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_arcs.insert(expected_arcs.size(), predict_arc_distance(position_pair_t'({
          in_tdata[29:0], in_tdata[60:30], in_tdata[90:61], in_tdata[121:91]})));
        accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          position_pair_t p;
          p = pending_pairs.pop_front();
          in_tdata <= {6'b0, p.lon2, p.lat2, p.lon1, p.lat1};
          in_tvalid <= 1'b1;
          if (!quiet && $urandom_range(9) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, field-by-field compare against oldest.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_arcs.size() == 0) begin
          $display("%0t: unexpected result arc=%0d dist=%0d", $time,
                   out_tdata[29:0], out_tdata[58:30]);
          errors++;
        end else begin
          arc_distance_t e;
          e = expected_arcs.pop_front();
          checked++;
          if (out_tdata[29:0] !== e.arc) begin
            $display("%0t: central_arc expected %0d actual %0d", $time,
                     e.arc, out_tdata[29:0]);
            errors++;
          end
          if (out_tdata[58:30] !== e.surf_dist) begin
            $display("%0t: surface_distance expected %0d actual %0d", $time,
                     e.surf_dist, out_tdata[58:30]);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!quiet && $urandom_range(9) == 0) recv_gap = $urandom_range(1, 13);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic position_pair_t mk(longint a, longint b, longint c, longint d);
    position_pair_t p;
    p.lat1 = LAT_W'(a);
    p.lon1 = LON_W'(b);
    p.lat2 = LAT_W'(c);
    p.lon2 = LON_W'(d);
    return p;
  endfunction

  function automatic longint rnd_lat();
    return longint'($urandom_range(754974720)) - 377487360;
  endfunction

  function automatic longint rnd_lon();
    return longint'($urandom_range(1509949440)) - 754974720;
  endfunction

  initial begin
    longint q, h, lmax, lmin, omax, omin;
    q = QUARTER_TURN;
    h = HALF_TURN;
    lmax = (64'sd1 << 29) - 1;
    lmin = -(64'sd1 << 29);
    omax = (64'sd1 << 30) - 1;
    omin = -(64'sd1 << 30);
    // directed: equal points, poles, date line, antipodes, out-of-range fields
    queue_pair(mk(0, 0, 0, 0));
    queue_pair(mk(123456789, -98765432, 123456789, -98765432));
    queue_pair(mk(q, 0, -q, 0));
    queue_pair(mk(0, 0, 0, h));
    queue_pair(mk(0, -h, 0, h));
    queue_pair(mk(0, h, 0, -h + 1));
    queue_pair(mk(q, h, q, -h));
    queue_pair(mk(-q, -h, -q, h));
    queue_pair(mk(10000000, 20000000, -10000000, 20000000 - h));
    queue_pair(mk(q, 0, q, 300000000));
    queue_pair(mk(lmax, omax, lmin, omin));
    queue_pair(mk(lmin, omin, lmax, omax));
    queue_pair(mk(lmax, 0, 0, 0));
    queue_pair(mk(lmin, 0, lmax, 0));
    queue_pair(mk(q + 1000, 5000, q - 1000, 5000));
    queue_pair(mk(-q - 50000000, 0, 0, 100000000));
    queue_pair(mk(0, omax, 0, omin));
    queue_pair(mk(1, 1, 0, 0));
    queue_pair(mk(-1, -1, 0, 0));
    queue_pair(mk(200000000, 700000000, -200000000, -700000000));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < N_RANDOM; n++) begin
      longint a, b;
      int kind;
      while (pending_pairs.size() > 8) @(posedge clk);
      if (n == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      kind = $urandom_range(9);
      a = rnd_lat();
      b = rnd_lon();
      if (kind < 5) begin
        queue_pair(mk(rnd_lat(), rnd_lon(), rnd_lat(), rnd_lon()));
      end else if (kind < 7) begin
        // nearby points, the usual track step
        queue_pair(mk(a, b, a + $signed($urandom_range(2000000)) - 1000000,
                      b + $signed($urandom_range(2000000)) - 1000000));
      end else if (kind == 7) begin
        // near-antipodal
        queue_pair(mk(a, b, -a + $signed($urandom_range(2000)) - 1000,
                      (b > 0 ? b - h : b + h)));
      end else begin
        // any bit pattern the fields allow
        queue_pair(mk($urandom, $urandom, $urandom, $urandom));
      end
    end
    while (pending_pairs.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_arcs.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (expected_arcs.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, expected_arcs.size());
      errors++;
    end
    $display("Sent %0d position pairs (poles, date line, antipodes, raw fields),", accepted);
    $display("checked %0d arc/distance results, %0d errors.", checked, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
rtl/hgcd_pkg.sv
rtl/haversine_great_circle_distance_unit.sv
tb/tb_haversine_great_circle_distance_unit.sv
